// ----- design/lfbd_pkg.sv -----
// ----------------------------------------------------------------------------
// LZSS flag-byte decoder package
// Shared constants, payload structs, command format and state encodings.
// ----------------------------------------------------------------------------
package lfbd_pkg;

	localparam int WINDOW_DEPTH        = 4096;
	localparam int WIN_AW              = $clog2(WINDOW_DEPTH);
	localparam int COUNT_BITS_DEFAULT  = 24;
	localparam int CMDQ_DEPTH_DEFAULT  = 4;
	localparam int OUTQ_DEPTH_DEFAULT  = 4;
	localparam int TOKENS_PER_FLAG     = 8;
	localparam int MIN_MATCH           = 3;
	localparam int RUN_W               = 5;
	localparam int CFG_IDX_W           = 2;
	localparam int CFG_DATA_W          = 24;

	localparam logic [WIN_AW-1:0]    START_RESET        = 12'hFEE;
	localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH  = 2'd1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       done_res;
	} out_item_t;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_LIT,
		PH_LO,
		PH_HI
	} token_phase_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_LIT,
		CMD_COPY
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t             op;
		logic [7:0]          data;
		logic [WIN_AW-1:0]   src;
		logic [RUN_W-1:0]    len;
		logic                done;
		logic                clear;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LIT,
		BK_READ,
		BK_WRITE
	} back_state_t;

endpackage

// ----- design/lfbd_fifo.sv -----
// ----------------------------------------------------------------------------
// LZSS decoder queue
// Small flop-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module lfbd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ----- design/lfbd_ram.sv -----
// ----------------------------------------------------------------------------
// LZSS decoder RAM
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lfbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/lfbd_front.sv -----
// ----------------------------------------------------------------------------
// LZSS decoder front end
// Parses flag, literal and match bytes, tracks the output count and issues
// one command per token that produces bytes or per end of stream.
// ----------------------------------------------------------------------------
module lfbd_front import lfbd_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  in_item_t              in_item,
	output logic                  full,
	input  logic [COUNT_BITS-1:0] out_len,
	input  logic                  clearing,
	output logic                  cmd_push,
	output cmd_t                  cmd,
	input  logic                  cmd_full
);

	token_phase_t          phase_q, phase_d, nt_phase;
	logic [7:0]            flag_q, flag_d, nt_flag;
	logic [2:0]            tok_q, tok_d, nt_tok;
	logic [7:0]            low_q, low_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic                  accept;
	logic                  active;
	logic                  emit;
	logic                  cut;
	logic [COUNT_BITS-1:0] remain;
	logic [COUNT_BITS-1:0] step;
	logic [COUNT_BITS-1:0] new_count;
	logic [RUN_W-1:0]      reps;
	logic [RUN_W-1:0]      run_len;

	assign full      = cmd_full | clearing;
	assign accept    = push & ~full;
	assign active    = (count_q < out_len);
	assign remain    = out_len - count_q;
	assign reps      = RUN_W'(in_item.in_byte[3:0]) + RUN_W'(MIN_MATCH);
	assign step      = (phase_q == PH_HI) ? COUNT_BITS'(reps) : COUNT_BITS'(1);
	assign cut       = (phase_q == PH_HI) && (remain < step);
	assign run_len   = cut ? remain[RUN_W-1:0] : reps;
	assign new_count = cut ? out_len : count_q + step;

	// advance to the next token of the current flag byte, or back to the flag phase after its last token
	always_comb begin
		nt_flag = flag_q >> 1;
		if (tok_q == '0) begin
			nt_phase = PH_FLAG;
			nt_tok   = '0;
		end else begin
			nt_phase = flag_q[1] ? PH_LIT : PH_LO;
			nt_tok   = tok_q - 3'd1;
		end
	end

	always_comb begin
		phase_d = phase_q;
		flag_d  = flag_q;
		tok_d   = tok_q;
		low_d   = low_q;
		count_d = count_q;
		if (accept) begin
			if (in_item.stream_end) begin
				phase_d = PH_FLAG;
				flag_d  = '0;
				tok_d   = '0;
				low_d   = '0;
				count_d = '0;
			end else if (active) begin
				unique case (phase_q)
					PH_FLAG: begin
						flag_d  = in_item.in_byte;
						tok_d   = 3'(TOKENS_PER_FLAG - 1);
						phase_d = in_item.in_byte[0] ? PH_LIT : PH_LO;
					end
					PH_LIT: begin
						count_d = new_count;
						phase_d = nt_phase;
						flag_d  = nt_flag;
						tok_d   = nt_tok;
					end
					PH_LO: begin
						low_d   = in_item.in_byte;
						phase_d = PH_HI;
					end
					PH_HI: begin
						count_d = new_count;
						phase_d = nt_phase;
						flag_d  = nt_flag;
						tok_d   = nt_tok;
					end
					default: phase_d = PH_FLAG;
				endcase
			end
		end
	end

	always_comb begin
		emit      = accept && active && (phase_q == PH_LIT || phase_q == PH_HI);
		cmd_push  = accept && (emit || in_item.stream_end);
		cmd.data  = in_item.in_byte;
		cmd.src   = {in_item.in_byte[7:4], low_q};
		cmd.done  = (new_count == out_len);
		cmd.clear = in_item.stream_end;
		if (!emit) begin
			cmd.op  = CMD_NONE;
			cmd.len = RUN_W'(1);
		end else if (phase_q == PH_LIT) begin
			cmd.op  = CMD_LIT;
			cmd.len = RUN_W'(1);
		end else begin
			cmd.op  = CMD_COPY;
			cmd.len = run_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			flag_q  <= '0;
			tok_q   <= '0;
			low_q   <= '0;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			flag_q  <= flag_d;
			tok_q   <= tok_d;
			low_q   <= low_d;
			count_q <= count_d;
		end
	end

endmodule

// ----- design/lfbd_back.sv -----
// ----------------------------------------------------------------------------
// LZSS decoder back end
// Executes literal, copy and clear commands against the window RAM and
// pushes decoded bytes into the result queue.
// ----------------------------------------------------------------------------
module lfbd_back import lfbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start_load,
	input  logic [WIN_AW-1:0] start_value,
	input  logic              cmd_empty,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	input  logic              out_full,
	output logic              out_push,
	output out_item_t         out_item,
	output logic              clearing
);

	back_state_t       state_q, state_d;
	logic [WIN_AW-1:0] clr_q;
	logic [WIN_AW-1:0] wi_q;
	logic [WIN_AW-1:0] src_q;
	logic [RUN_W-1:0]  left_q;
	logic [7:0]        lit_q;
	logic              done_q;
	logic              clear_q;
	logic              last;
	logic              ram_we;
	logic [WIN_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [7:0]        ram_rdata;

	lfbd_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (src_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_q == WIN_AW'(WINDOW_DEPTH - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd.op)
						CMD_LIT:  state_d = BK_LIT;
						CMD_COPY: state_d = BK_READ;
						default:  state_d = cmd.clear ? BK_CLEAR : BK_IDLE;
					endcase
				end
			end
			BK_LIT: begin
				if (!out_full) begin
					state_d = clear_q ? BK_CLEAR : BK_IDLE;
				end
			end
			BK_READ: state_d = BK_WRITE;
			BK_WRITE: begin
				if (!out_full) begin
					if (left_q == RUN_W'(1)) begin
						state_d = clear_q ? BK_CLEAR : BK_IDLE;
					end else begin
						state_d = BK_READ;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop            = (state_q == BK_IDLE) && !cmd_empty;
		clearing           = (state_q == BK_CLEAR);
		ram_re             = (state_q == BK_READ);
		out_push           = (state_q == BK_LIT || state_q == BK_WRITE) && !out_full;
		last               = (state_q == BK_LIT) || (left_q == RUN_W'(1));
		out_item.out_byte  = (state_q == BK_LIT) ? lit_q : ram_rdata;
		out_item.run_last  = last;
		out_item.done_res  = last & done_q;
		ram_we             = clearing | out_push;
		ram_waddr          = clearing ? clr_q : wi_q;
		ram_wdata          = clearing ? 8'h00 : out_item.out_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			wi_q    <= START_RESET;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + WIN_AW'(1);
			end
			if (start_load) begin
				wi_q <= start_value;
			end else if (clearing && state_d == BK_IDLE) begin
				wi_q <= start_value;
			end else if (out_push) begin
				wi_q <= wi_q + WIN_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			lit_q   <= cmd.data;
			src_q   <= cmd.src;
			left_q  <= cmd.len;
			done_q  <= cmd.done;
			clear_q <= cmd.clear;
		end else begin
			if (ram_re) begin
				src_q <= src_q + WIN_AW'(1);
			end
			if (out_push && state_q == BK_WRITE) begin
				left_q <= left_q - RUN_W'(1);
			end
		end
	end

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("window read and write in the same cycle");

	a_read_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_READ |=> state_q == BK_WRITE)
		else $error("copy read not followed by write");

	a_copy_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_READ || state_q == BK_WRITE) |-> left_q != '0)
		else $error("copy running with no bytes left");

	a_clear_runs_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLEAR && clr_q != WIN_AW'(WINDOW_DEPTH - 1)) |=> state_q == BK_CLEAR)
		else $error("clear pass left early");

endmodule

// ----- design/lzss_flag_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// LZSS flag-byte decoder
// Decodes a byte-oriented LZSS stream with a 4096-byte window, 12-bit
// positions and 4-bit lengths into decoded bytes.
// ----------------------------------------------------------------------------
// Both data sides are queues: push compressed bytes while full is low, pop
// decoded bytes while empty is low; run_last marks the final byte caused by
// one input byte, done_res the byte that reaches output_length. After reset
// and after every input byte flagged stream_end the window RAM is zeroed in a
// clearing pass during which no input byte is taken (configuration writes
// are always taken, cfg_ready stays high). The front end takes one compressed
// byte per cycle while its command queue has room and no clearing pass runs;
// the back end takes a new command only when idle, writes a literal out in its
// literal state and copies a match byte by byte through its read and write
// states, since each copied byte waits on the registered read of the window
// RAM before it is written back. Throughput therefore follows the token mix
// and the lengths of the matches.
module lzss_flag_byte_decoder import lfbd_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
	parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEFAULT,
	parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  in_item_t              in_data,
	output logic                  full,
	input  logic                  pop,
	output out_item_t             out_data,
	output logic                  empty,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [WIN_AW-1:0]     start_q;
	logic [COUNT_BITS-1:0] len_q;
	logic                  start_wr;
	logic                  len_wr;
	logic [WIN_AW-1:0]     start_value;
	logic                  clearing;
	logic                  cmd_push;
	logic                  cmd_pop;
	logic                  cmd_full;
	logic                  cmd_empty;
	cmd_t                  cmd_in;
	logic [$bits(cmd_t)-1:0]      cmd_raw;
	logic                  res_push;
	logic                  res_full;
	out_item_t             res_item;
	logic [$bits(out_item_t)-1:0] res_raw;

	assign cfg_ready = 1'b1;

	always_comb begin
		start_wr = 1'b0;
		len_wr   = 1'b0;
		if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_POSITION: start_wr = 1'b1;
				REG_OUTPUT_LENGTH:  len_wr   = 1'b1;
				default: ;
			endcase
		end
	end

	assign start_value = start_wr ? cfg_data[WIN_AW-1:0] : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			len_q   <= '0;
		end else begin
			if (start_wr) begin
				start_q <= cfg_data[WIN_AW-1:0];
			end
			if (len_wr) begin
				len_q <= COUNT_BITS'(cfg_data);
			end
		end
	end

	lfbd_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_item  (in_data),
		.full     (full),
		.out_len  (len_q),
		.clearing (clearing),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	lfbd_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_raw),
		.empty   (cmd_empty)
	);

	lfbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_load  (start_wr),
		.start_value (start_value),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd_t'(cmd_raw)),
		.cmd_pop     (cmd_pop),
		.out_full    (res_full),
		.out_push    (res_push),
		.out_item    (res_item),
		.clearing    (clearing)
	);

	lfbd_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_item),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_raw),
		.empty   (empty)
	);

	assign out_data = out_item_t'(res_raw);

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// LZSS flag-byte decoder testbench
// Feeds compressed bytes through the push/full queue port and checks every
// popped decoded byte against a cycle-free decoder model kept in the bench.
// A directed table covers the register extremes, both token kinds, window
// wrap, overlapping copies, cut-short matches and truncated tokens. Random
// streams, mostly well formed, follow under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
	import lfbd_pkg::*;

	localparam int HOLD_OFF    = 4200;
	localparam int TAIL_CYCLES = 300;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASES      = 8;
	localparam int PHASE_GOAL  = 35;
	localparam int PHASE_CAP   = 70;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum {ROW_PRED, ROW_NONE, ROW_ONE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [7:0]            in_byte;
		logic                  stream_end;
		logic [7:0]            want_byte;
		logic                  want_done;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
	} row_t;

	row_t plan [28] = '{
		'{ROW_NONE, 8'h00, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_NONE, 8'hFF, 1'b1, 8'h00, 1'b0, '0, '0},
		'{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, REG_START_POSITION, 24'hFFF000},
		'{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, REG_OUTPUT_LENGTH, 24'd30},
		'{ROW_NONE, 8'h05, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_ONE,  8'h00, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_NONE, 8'h00, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_PRED, 8'h0F, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_ONE,  8'hFF, 1'b0, 8'hFF, 1'b0, '0, '0},
		'{ROW_NONE, 8'h13, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_PRED, 8'h02, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_NONE, 8'hFF, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_PRED, 8'hFF, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_NONE, 8'hAB, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_NONE, 8'h00, 1'b1, 8'h00, 1'b0, '0, '0},
		'{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, REG_START_POSITION, 24'h000FFF},
		'{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, REG_OUTPUT_LENGTH, 24'hFFFFFF},
		'{ROW_NONE, 8'hFE, 1'b1, 8'h00, 1'b0, '0, '0},
		'{ROW_NONE, 8'h00, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_NONE, 8'h10, 1'b1, 8'h00, 1'b0, '0, '0},
		'{ROW_NONE, 8'h01, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_ONE,  8'h80, 1'b0, 8'h80, 1'b0, '0, '0},
		'{ROW_NONE, 8'hFF, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_PRED, 8'hF1, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_NONE, 8'h55, 1'b0, 8'h00, 1'b0, '0, '0},
		'{ROW_PRED, 8'hA7, 1'b1, 8'h00, 1'b0, '0, '0},
		'{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, REG_SPARE_2, 24'hABCDEF},
		'{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, REG_SPARE_3, 24'h123456}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	in_item_t              in_data = '0;
	logic                  full;
	logic                  pop = 1'b0;
	out_item_t             out_data;
	logic                  empty;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	lzss_flag_byte_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_data   (in_data),
		.full      (full),
		.pop       (pop),
		.out_data  (out_data),
		.empty     (empty),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// decoder model state
	logic [7:0]         d_win [WINDOW_DEPTH];
	logic [WIN_AW-1:0]  d_wr;
	logic [15:0]        d_flags;
	token_phase_t       d_phase;
	logic [7:0]         d_lo;
	logic [23:0]        d_count;
	logic [WIN_AW-1:0]  d_start;
	logic [23:0]        d_len;

	out_item_t decoded_q [$];
	out_item_t want;

	int send_pct = 0;
	int recv_pct = 0;
	int n_bytes = 0;
	int n_live = 0;
	int n_checked = 0;
	int n_writes = 0;
	int n_err = 0;
	int quiet = 0;

	function automatic void clear_stream();
		foreach (d_win[i])
			d_win[i] = 8'h00;
		d_wr = d_start;
		d_flags = '0;
		d_phase = PH_FLAG;
		d_lo = '0;
		d_count = '0;
	endfunction

	function automatic void expect_item(out_item_t x);
		decoded_q = {decoded_q, x};
	endfunction

	function automatic void put_byte(logic [7:0] b);
		d_win[d_wr] = b;
		d_wr = d_wr + 1'b1;
		d_count = d_count + 1'b1;
		expect_item(out_item_t'{b, 1'b0, d_count == d_len});
	endfunction

	function automatic void next_token();
		d_flags = d_flags >> 1;
		if (!d_flags[8])
			d_phase = PH_FLAG;
		else
			d_phase = d_flags[0] ? PH_LIT : PH_LO;
	endfunction

	function automatic bit decode_byte(in_item_t it);
		logic [WIN_AW-1:0] src;
		int                reps;
		int                made;
		bit                live;
		made = 0;
		live = d_count < d_len;
		if (live) begin
			case (d_phase)
				PH_FLAG: begin
					d_flags = {8'hFF, it.in_byte};
					d_phase = d_flags[0] ? PH_LIT : PH_LO;
				end
				PH_LIT: begin
					put_byte(it.in_byte);
					made++;
					next_token();
				end
				PH_LO: begin
					d_lo = it.in_byte;
					d_phase = PH_HI;
				end
				default: begin
					src = {it.in_byte[7:4], d_lo};
					reps = it.in_byte[3:0] + MIN_MATCH;
					while (reps > 0 && d_count < d_len) begin
						put_byte(d_win[src]);
						src = src + 1'b1;
						made++;
						reps--;
					end
					next_token();
				end
			endcase
		end
		if (made > 0)
			decoded_q[decoded_q.size() - 1].run_last = 1'b1;
		if (it.stream_end)
			clear_stream();
		return live;
	endfunction

	task automatic send_item(in_item_t it);
		while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		n_bytes++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		drain();
		repeat (HOLD_OFF) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		n_writes++;
		case (idx)
			REG_START_POSITION: begin
				d_start = val[WIN_AW-1:0];
				d_wr = val[WIN_AW-1:0];
			end
			REG_OUTPUT_LENGTH: d_len = val;
			default: ;
		endcase
	endtask

	task automatic run_stream();
		in_item_t          it;
		logic [7:0]        code [$];
		logic [7:0]        flg;
		logic [WIN_AW-1:0] pos;
		logic [WIN_AW-1:0] src;
		logic [3:0]        len;
		int                kind;
		bit                ends;
		kind = $urandom_range(0, 15);
		pos = d_wr;
		if (kind == 0) begin
			repeat ($urandom_range(1, 40)) code = {code, 8'($urandom)};
		end else begin
			repeat ($urandom_range(1, 4)) begin
				flg = 8'($urandom);
				code = {code, flg};
				for (int t = 0; t < TOKENS_PER_FLAG; t++) begin
					if (flg[t]) begin
						code = {code, 8'($urandom)};
						pos = pos + 1'b1;
					end else begin
						len = 4'($urandom);
						if ($urandom_range(0, 3) != 0)
							src = pos - 12'($urandom_range(1, 400));
						else
							src = 12'($urandom);
						code = {code, src[7:0]};
						code = {code, src[11:8], len};
						pos = pos + 12'(len) + 12'(MIN_MATCH);
					end
				end
			end
			if (kind == 1)
				code = code[0:$urandom_range(0, code.size() - 1)];
		end
		ends = (kind < 2) || ($urandom_range(0, 3) != 0);
		foreach (code[i]) begin
			it.in_byte = code[i];
			it.stream_end = ends && (i == code.size() - 1);
			if (decode_byte(it))
				n_live++;
			send_item(it);
		end
	endtask

	always @(posedge clk) begin
		if (pop && !empty) begin
			if (decoded_q.size() == 0) begin
				$error("decoded byte %02h popped with nothing expected", out_data.out_byte);
				n_err++;
			end else begin
				want = decoded_q.pop_front();
				n_checked++;
				if (out_data.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte,
						out_data.out_byte);
					n_err++;
				end
				if (out_data.run_last !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, out_data.run_last);
					n_err++;
				end
				if (out_data.done_res !== want.done_res) begin
					$error("done_res: expected %b, got %b", want.done_res, out_data.done_res);
					n_err++;
				end
			end
		end
		pop <= (recv_pct == 0) || ($urandom_range(0, 99) >= recv_pct);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		in_item_t          it;
		int                mark;
		int                goal;
		int                cap;
		bit                paused;
		logic [WIN_AW-1:0] st;
		logic [23:0]       ln;
		d_start = START_RESET;
		d_len = '0;
		clear_stream();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				it.in_byte = plan[i].in_byte;
				it.stream_end = plan[i].stream_end;
				mark = decoded_q.size();
				if (decode_byte(it))
					n_live++;
				if (plan[i].kind != ROW_PRED) begin
					while (decoded_q.size() > mark)
						void'(decoded_q.pop_back());
					if (plan[i].kind == ROW_ONE)
						expect_item(out_item_t'{plan[i].want_byte, 1'b1,
							plan[i].want_done});
				end
				send_item(it);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 52; recv_pct = 0;  end
				2: begin send_pct = 0;  recv_pct = 52; end
				default: begin send_pct = 15; recv_pct = 15; end
			endcase
			st = 12'($urandom);
			case (ph)
				0: begin st = START_RESET; ln = '1; end
				1: begin st = '0; ln = '1; end
				2: begin st = '1; ln = 24'($urandom_range(100, 400)); end
				4: ln = 24'($urandom_range(1, 40));
				5: ln = '0;
				6: ln = 24'($urandom_range(200, 2000));
				default: ln = '1;
			endcase
			write_reg(REG_START_POSITION, {12'($urandom), st});
			write_reg(REG_OUTPUT_LENGTH, ln);
			goal = n_live + PHASE_GOAL;
			cap = n_bytes + PHASE_CAP;
			paused = 1'b0;
			while (n_live < goal && n_bytes < cap) begin
				run_stream();
				if (!paused && n_live >= goal - PHASE_GOAL / 2) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d compressed bytes (%0d decoded, rest ignored) and %0d register writes",
			n_bytes, n_live, n_writes);
		$display("checked %0d decoded bytes over %0d idle/stall phases", n_checked, PHASES);
		if (decoded_q.size() != 0) begin
			$error("%0d decoded bytes never arrived", decoded_q.size());
			n_err++;
		end
		if (n_err == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/lfbd_pkg.sv
design/lfbd_fifo.sv
design/lfbd_ram.sv
design/lfbd_front.sv
design/lfbd_back.sv
design/lzss_flag_byte_decoder.sv
bench/tb.sv
